FILE: hdl/byte_bus_mul_div_unit_defines.svh
// Assertion macros for the byte-bus multiply/divide unit.
// Depends on nothing; included by the top level only.
`ifndef BYTE_BUS_MUL_DIV_UNIT_DEFINES_SVH
`define BYTE_BUS_MUL_DIV_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BBMDU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BBMDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/bbmdu_pkg.sv
// Constants for the byte-bus multiply/divide unit: register offsets, widths, function codes and last steps.
// Depends on nothing.
package bbmdu_pkg;

  localparam int unsigned OffW  = 4;
  localparam int unsigned DataW = 8;

  localparam logic [OffW-1:0] OFF_DIVD_B0 = 4'd0;
  localparam logic [OffW-1:0] OFF_DIVD_B1 = 4'd1;
  localparam logic [OffW-1:0] OFF_DIVD_B2 = 4'd2;
  localparam logic [OffW-1:0] OFF_DIVD_B3 = 4'd3;
  localparam logic [OffW-1:0] OFF_MULR_LO = 4'd4;
  localparam logic [OffW-1:0] OFF_MULR_HI = 4'd5;
  localparam logic [OffW-1:0] OFF_DIVR_LO = 4'd6;
  localparam logic [OffW-1:0] OFF_DIVR_HI = 4'd7;
  localparam logic [OffW-1:0] OFF_RES_B0  = 4'd8;
  localparam logic [OffW-1:0] OFF_RES_B1  = 4'd9;
  localparam logic [OffW-1:0] OFF_RES_B2  = 4'd10;
  localparam logic [OffW-1:0] OFF_RES_B3  = 4'd11;
  localparam logic [OffW-1:0] OFF_REM_LO  = 4'd12;
  localparam logic [OffW-1:0] OFF_REM_HI  = 4'd13;
  localparam logic [OffW-1:0] OFF_MODE    = 4'd14;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [4:0] MUL_LAST_STEP = 5'd15;
  localparam logic [4:0] DIV_LAST_STEP = 5'd31;

endpackage

FILE: hdl/byte_bus_mul_div_unit.sv
// Byte-bus multiply/divide unit. Any transfer, a start too, answers in the next cycle.
// A multiply start keeps the unit busy through its shift-add steps and sign fixup; a divide
// start with a nonzero divisor, through its shift-subtract steps and two sign fixups (one
// step per cycle on a shared 33-bit adder). The next transfer waits until the unit is idle.
// Reset (rst_ni, asynchronous) clears every register and selects unsigned mode.
// Depends on bbmdu_pkg and byte_bus_mul_div_unit_defines.svh.
`include "byte_bus_mul_div_unit_defines.svh"

module byte_bus_mul_div_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [bbmdu_pkg::OffW-1:0]    reg_offset_i,
  input  logic [bbmdu_pkg::DataW-1:0]   write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbmdu_pkg::DataW-1:0]   read_data_o
);
  import bbmdu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIXQ,
    ST_FIXR
  } state_e;

  state_e      state_q;
  logic [31:0] dividend_q;
  logic [15:0] multiplier_q;
  logic [15:0] divisor_q;
  logic [31:0] result_q;
  logic [15:0] remainder_q;
  logic        signed_q;

  logic [31:0] acc_q;
  logic [31:0] opa_q;
  logic [15:0] opb_q;
  logic [4:0]  cnt_q;
  logic        is_div_q;
  logic        neg_res_q;
  logic        neg_rem_q;

  logic        out_valid_q;
  logic [7:0]  read_data_q;

  logic        in_xfer;
  logic [7:0]  rd_byte;
  logic [15:0] mulr_new;
  logic [15:0] divr_new;
  logic        mul_a_neg;
  logic        mul_b_neg;
  logic        div_n_neg;
  logic        div_d_neg;

  logic [32:0] add_a;
  logic [32:0] add_b;
  logic        add_sub;
  logic [32:0] add_sum;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  assign mulr_new  = {write_data_i, multiplier_q[7:0]};
  assign divr_new  = {write_data_i, divisor_q[7:0]};
  assign mul_a_neg = signed_q & dividend_q[15];
  assign mul_b_neg = signed_q & mulr_new[15];
  assign div_n_neg = signed_q & dividend_q[31];
  assign div_d_neg = signed_q & divr_new[15];

  always_comb begin
    unique case (reg_offset_i)
      OFF_DIVD_B0: rd_byte = dividend_q[7:0];
      OFF_DIVD_B1: rd_byte = dividend_q[15:8];
      OFF_DIVD_B2: rd_byte = dividend_q[23:16];
      OFF_DIVD_B3: rd_byte = dividend_q[31:24];
      OFF_MULR_LO: rd_byte = multiplier_q[7:0];
      OFF_MULR_HI: rd_byte = multiplier_q[15:8];
      OFF_DIVR_LO: rd_byte = divisor_q[7:0];
      OFF_DIVR_HI: rd_byte = divisor_q[15:8];
      OFF_RES_B0:  rd_byte = result_q[7:0];
      OFF_RES_B1:  rd_byte = result_q[15:8];
      OFF_RES_B2:  rd_byte = result_q[23:16];
      OFF_RES_B3:  rd_byte = result_q[31:24];
      OFF_REM_LO:  rd_byte = remainder_q[7:0];
      OFF_REM_HI:  rd_byte = remainder_q[15:8];
      default:     rd_byte = 8'd0;
    endcase
  end

  // The single adder/subtractor serves the multiply, divide and sign fixup steps.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      ST_MUL: begin
        add_a = {1'b0, acc_q};
        add_b = {1'b0, opa_q};
      end
      ST_DIV: begin
        add_a   = {16'd0, acc_q[15:0], opa_q[31]};
        add_b   = {17'd0, opb_q};
        add_sub = 1'b1;
      end
      ST_FIXQ: begin
        add_b   = {1'b0, (is_div_q ? opa_q : acc_q)};
        add_sub = 1'b1;
      end
      ST_FIXR: begin
        add_b   = {17'd0, acc_q[15:0]};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dividend_q   <= '0;
      multiplier_q <= '0;
      divisor_q    <= '0;
      result_q     <= '0;
      remainder_q  <= '0;
      signed_q     <= 1'b0;
      acc_q        <= '0;
      opa_q        <= '0;
      opb_q        <= '0;
      cnt_q        <= '0;
      is_div_q     <= 1'b0;
      neg_res_q    <= 1'b0;
      neg_rem_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      read_data_q  <= '0;
    end else begin
      if (in_xfer) begin
        out_valid_q <= 1'b1;
        read_data_q <= (func_i == FUNC_WRITE) ? 8'd0 : rd_byte;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && (func_i == FUNC_WRITE)) begin
            unique case (reg_offset_i)
              OFF_DIVD_B0: dividend_q[7:0]   <= write_data_i;
              OFF_DIVD_B1: dividend_q[15:8]  <= write_data_i;
              OFF_DIVD_B2: dividend_q[23:16] <= write_data_i;
              OFF_DIVD_B3: dividend_q[31:24] <= write_data_i;
              OFF_MULR_LO: multiplier_q[7:0] <= write_data_i;
              OFF_MULR_HI: begin
                multiplier_q <= mulr_new;
                acc_q        <= '0;
                opa_q        <= {16'd0, (mul_a_neg ? (16'd0 - dividend_q[15:0])
                                                   : dividend_q[15:0])};
                opb_q        <= mul_b_neg ? (16'd0 - mulr_new) : mulr_new;
                neg_res_q    <= mul_a_neg ^ mul_b_neg;
                is_div_q     <= 1'b0;
                cnt_q        <= '0;
                state_q      <= ST_MUL;
              end
              OFF_DIVR_LO: divisor_q[7:0] <= write_data_i;
              OFF_DIVR_HI: begin
                divisor_q <= divr_new;
                if (divr_new == 16'd0) begin
                  result_q    <= '0;
                  remainder_q <= dividend_q[15:0];
                end else begin
                  acc_q     <= '0;
                  opa_q     <= div_n_neg ? (32'd0 - dividend_q) : dividend_q;
                  opb_q     <= div_d_neg ? (16'd0 - divr_new) : divr_new;
                  neg_res_q <= div_n_neg ^ div_d_neg;
                  neg_rem_q <= div_n_neg;
                  is_div_q  <= 1'b1;
                  cnt_q     <= '0;
                  state_q   <= ST_DIV;
                end
              end
              OFF_MODE: begin
                signed_q     <= write_data_i[0];
                dividend_q   <= '0;
                multiplier_q <= '0;
                divisor_q    <= '0;
                result_q     <= '0;
                remainder_q  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL: begin
          if (opb_q[0]) begin
            acc_q <= add_sum[31:0];
          end
          opa_q <= {opa_q[30:0], 1'b0};
          opb_q <= {1'b0, opb_q[15:1]};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == MUL_LAST_STEP) begin
            state_q <= ST_FIXQ;
          end
        end
        ST_DIV: begin
          if (!add_sum[32]) begin
            acc_q[15:0] <= add_sum[15:0];
          end else begin
            acc_q[15:0] <= {acc_q[14:0], opa_q[31]};
          end
          opa_q <= {opa_q[30:0], !add_sum[32]};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == DIV_LAST_STEP) begin
            state_q <= ST_FIXQ;
          end
        end
        ST_FIXQ: begin
          result_q <= neg_res_q ? add_sum[31:0] : (is_div_q ? opa_q : acc_q);
          state_q  <= is_div_q ? ST_FIXR : ST_IDLE;
        end
        ST_FIXR: begin
          remainder_q <= neg_rem_q ? add_sum[15:0] : acc_q[15:0];
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `BBMDU_ASSERT_NEXT(a_xfer_gives_answer, clk_i, rst_ni, in_xfer, out_valid_o)
  `BBMDU_ASSERT_SAME(a_busy_not_ready, clk_i, rst_ni, state_q != ST_IDLE, !in_ready_o)
  `BBMDU_ASSERT_NEXT(a_write_reads_zero, clk_i, rst_ni, in_xfer && (func_i == FUNC_WRITE), read_data_o == 8'd0)

endmodule
